FILE: src/bitmap_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// bitmap block allocator assertion macros
// shared property wrappers clocked on clk_i and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

FILE: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// types and constants of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF  = 32;

  localparam int unsigned TOTAL_W   = 11;
  localparam int unsigned BLK_NUM_W = 10;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                 command;
    logic [BLK_NUM_W-1:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [BLK_NUM_W-1:0] allocated_block;
    status_e              status;
  } out_item_t;

endpackage

FILE: src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a one-bit-per-block used map
// ----------------------------------------------------------------------------
// Commands arrive on the in channel (in_valid_i / in_stall_o) as in_item_t:
// allocate returns the lowest free block below the active count, free clears
// the given block. Each item gives one out_item_t on the out channel
// (out_valid_o / out_stall_i). total_blocks is written on the cfg channel,
// which is always ready; the active count is min(total_blocks, NUM_BLOCKS).
// The map sits in a one-port-read, one-port-write memory of MAP_WORDS words.
// An allocate reads one word per cycle until it finds a free bit or reaches
// the last word below the active count, reading at most MAP_WORDS words. A
// free goes through divide, read, modify and respond; a free out of range and
// an allocate with a zero count go from the accept straight to respond. One
// item is in work at a time; the next is taken the cycle after the result
// enters the output register, while that result may still be waiting. A
// stalled receiver holds the result and the block then waits with the next
// result ready. After reset a clearing pass zeroes all MAP_WORDS words of the
// map (32 at the defaults), one word a cycle, with in_stall_o high.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_defines.svh"

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [TOTAL_W-1:0] cfg_data_i
);

  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SH_W      = $clog2(WORD_BITS);
  localparam int unsigned CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LIM_W     = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam int unsigned RECIP_K   = 16;
  localparam int unsigned RECIP_M   = (2 ** RECIP_K) / WORD_BITS;
  localparam int unsigned PROD_W    = BLK_NUM_W + RECIP_K;
  localparam int unsigned R0_W      = BLK_NUM_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACHK,
    S_FRD,
    S_FCHK,
    S_RESP
  } state_e;

  state_e               state_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [WIDX_W-1:0]    clr_idx_q;
  logic [LIM_W-1:0]     lim_q;
  logic [LIM_W-1:0]     base_q;
  logic [WIDX_W-1:0]    widx_q;
  logic [BLK_NUM_W-1:0] fr_blk_q;
  logic [BLK_NUM_W-1:0] fr_q0_q;
  logic [WIDX_W-1:0]    fr_widx_q;
  logic [SH_W-1:0]      fr_r_q;
  logic [BLK_NUM_W-1:0] res_blk_q;
  status_e              res_st_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;

  logic [LIM_W-1:0]     lim_c;
  logic                 accept;
  logic [PROD_W-1:0]    recip_prod;
  logic [R0_W-1:0]      fr_qw;
  logic [R0_W-1:0]      fr_r0;
  logic [R0_W-1:0]      fr_r_c;
  logic [BLK_NUM_W-1:0] fr_q_c;
  logic [LIM_W-1:0]     rem;
  logic [LIM_W:0]       base_next;
  logic                 last_word;
  logic [WORD_BITS-1:0] valid_mask;
  logic [LIM_W-1:0]     found_num;

  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WIDX_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 ffz_found;
  logic [SH_W-1:0]      ffz_idx;
  logic [WORD_BITS-1:0] ffz_low;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign lim_c = (LIM_W'(total_q) > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS)
                                                        : LIM_W'(total_q);

  // block / WORD_BITS by reciprocal, corrected by one step before the read
  assign recip_prod = PROD_W'(in_item_i.block_number) * PROD_W'(RECIP_M);
  assign fr_qw      = R0_W'(fr_q0_q) * R0_W'(WORD_BITS);
  assign fr_r0      = R0_W'(fr_blk_q) - fr_qw;

  always_comb begin
    if (fr_r0 >= R0_W'(WORD_BITS)) begin
      fr_q_c = fr_q0_q + BLK_NUM_W'(1);
      fr_r_c = fr_r0 - R0_W'(WORD_BITS);
    end else begin
      fr_q_c = fr_q0_q;
      fr_r_c = fr_r0;
    end
  end

  // scan window of the current word
  assign rem       = lim_q - base_q;
  assign base_next = {1'b0, base_q} + (LIM_W + 1)'(WORD_BITS);
  assign last_word = (base_next >= {1'b0, lim_q});
  assign found_num = base_q + LIM_W'(ffz_idx);

  always_comb begin
    if (rem >= LIM_W'(WORD_BITS)) begin
      valid_mask = '1;
    end else begin
      valid_mask = ~({WORD_BITS{1'b1}} << rem[SH_W-1:0]);
    end
  end

  bba_ffz #(
    .WIDTH (WORD_BITS),
    .IDX_W (SH_W)
  ) u_ffz (
    .word_i  (ram_rdata),
    .mask_i  (valid_mask),
    .found_o (ffz_found),
    .idx_o   (ffz_idx),
    .low_o   (ffz_low)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_re = accept && (in_item_i.command == CMD_ALLOC);
      end
      S_ACHK: begin
        if (ffz_found) begin
          ram_we    = 1'b1;
          ram_waddr = widx_q;
          ram_wdata = ram_rdata | ffz_low;
        end else if (!last_word) begin
          ram_re    = 1'b1;
          ram_raddr = widx_q + WIDX_W'(1);
        end
      end
      S_FRD: begin
        ram_re    = 1'b1;
        ram_raddr = WIDX_W'(fr_q_c);
      end
      S_FCHK: begin
        if (ram_rdata[fr_r_q]) begin
          ram_we    = 1'b1;
          ram_waddr = fr_widx_q;
          ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fr_r_q);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (WIDX_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      total_q     <= TOTAL_RESET;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + WIDX_W'(1);
          if (clr_idx_q == WIDX_W'(MAP_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            lim_q     <= lim_c;
            base_q    <= '0;
            widx_q    <= '0;
            fr_blk_q  <= in_item_i.block_number;
            fr_q0_q   <= recip_prod[PROD_W-1:RECIP_K];
            res_blk_q <= '0;
            if (in_item_i.command == CMD_ALLOC) begin
              if (lim_c == '0) begin
                res_st_q <= ST_FULL;
                state_q  <= S_RESP;
              end else begin
                state_q  <= S_ACHK;
              end
            end else if (LIM_W'(in_item_i.block_number) >= lim_c) begin
              res_st_q <= ST_RANGE;
              state_q  <= S_RESP;
            end else begin
              state_q  <= S_FRD;
            end
          end
        end
        S_ACHK: begin
          if (ffz_found) begin
            res_blk_q <= found_num[BLK_NUM_W-1:0];
            res_st_q  <= ST_OK;
            state_q   <= S_RESP;
          end else if (last_word) begin
            res_st_q  <= ST_FULL;
            state_q   <= S_RESP;
          end else begin
            base_q    <= base_next[LIM_W-1:0];
            widx_q    <= widx_q + WIDX_W'(1);
          end
        end
        S_FRD: begin
          fr_widx_q <= WIDX_W'(fr_q_c);
          fr_r_q    <= fr_r_c[SH_W-1:0];
          state_q   <= S_FCHK;
        end
        S_FCHK: begin
          res_st_q <= ram_rdata[fr_r_q] ? ST_OK : ST_ALREADY_FREE;
          state_q  <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q                <= 1'b1;
            out_item_q.allocated_block <= res_blk_q;
            out_item_q.status          <= res_st_q;
            state_q                    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `BBA_ASSERT_IMPL(a_scan_below_limit, state_q == S_ACHK, base_q < lim_q)
  `BBA_ASSERT_IMPL(a_free_rem_in_word, state_q == S_FRD, fr_r_c < R0_W'(WORD_BITS))
  `BBA_ASSERT_NEXT(a_alloc_hit_ok, (state_q == S_ACHK) && ffz_found, (state_q == S_RESP) && (res_st_q == ST_OK))
  `BBA_ASSERT_NEXT(a_resp_loads_out, (state_q == S_RESP) && (!out_valid_q || !out_stall_i), out_valid_q && (state_q == S_IDLE))
  `BBA_ASSERT_NEXT(a_clear_ends, (state_q == S_CLEAR) && (clr_idx_q == WIDX_W'(MAP_WORDS - 1)), state_q == S_IDLE)

endmodule

FILE: src/bba_map_ram.sv
// ----------------------------------------------------------------------------
// bba_map_ram
// used-map storage, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module bba_map_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/bba_ffz.sv
// ----------------------------------------------------------------------------
// bba_ffz
// lowest free bit of one map word among the bits enabled by the mask
// ----------------------------------------------------------------------------
module bba_ffz #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic [WIDTH-1:0] word_i,
  input  logic [WIDTH-1:0] mask_i,
  output logic             found_o,
  output logic [IDX_W-1:0] idx_o,
  output logic [WIDTH-1:0] low_o
);

  logic [WIDTH-1:0] free;

  assign free    = ~word_i & mask_i;
  assign low_o   = free & (~free + WIDTH'(1));
  assign found_o = |free;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (low_o[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

endmodule
